### rtl/mbrc_pkg.sv
// Shared constants, types and CRC helpers for the Modbus RTU reply checker.
package mbrc_pkg;

    localparam int MAX_FRAME = 64;
    localparam int CNT_W     = $clog2(MAX_FRAME + 2);
    localparam int LEN_W     = 9;
    localparam int TOT_W     = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] MIN_CNT     = CNT_W'(5);
    localparam logic [CNT_W-1:0] CRC_START   = CNT_W'(2);
    localparam logic [CNT_W-1:0] HDR_CRC_LEN = CNT_W'(3);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_MASK = 8'h80;

    // Register word index of the configuration port
    localparam logic REG_SLAVE_ID = 1'b0;

    // Supported function codes
    localparam logic [7:0] FN_READ_COILS      = 8'd1;
    localparam logic [7:0] FN_READ_DISC_IN    = 8'd2;
    localparam logic [7:0] FN_READ_HOLD_REGS  = 8'd3;
    localparam logic [7:0] FN_READ_IN_REGS    = 8'd4;
    localparam logic [7:0] FN_WRITE_COIL      = 8'd5;
    localparam logic [7:0] FN_WRITE_REG       = 8'd6;
    localparam logic [7:0] FN_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FN_WRITE_REGS      = 8'd16;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_BAD_ID  = 3'd2,
        ST_CRC     = 3'd3,
        ST_EXC     = 3'd4,
        ST_ILL_FN  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_slot;

    // Byte-wide reflected CRC-16 update, unrolled over eight bit steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic fn_known(input logic [7:0] f);
        logic known;
        case (f)
            FN_READ_COILS, FN_READ_DISC_IN, FN_READ_HOLD_REGS, FN_READ_IN_REGS,
            FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_COILS, FN_WRITE_REGS: known = 1'b1;
            default: known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

### rtl/mbrc_in_if.sv
// Byte stream channel carrying received reply bytes.
interface mbrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/mbrc_out_if.sv
// Result channel carrying one check report per frame.
interface mbrc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  function_code;
    logic [8:0]  payload_length;
    logic [15:0] success_count;
    logic [15:0] failure_count;
    logic [15:0] exception_count;
    logic [15:0] retry_count;

    modport source (
        output valid, output status, output function_code, output payload_length,
        output success_count, output failure_count, output exception_count,
        output retry_count, input ready
    );
    modport sink (
        input valid, input status, input function_code, input payload_length,
        input success_count, input failure_count, input exception_count,
        input retry_count, output ready
    );
endinterface

### rtl/mbrc_cfg.sv
// APB register block holding the expected slave address.
module mbrc_cfg
    import mbrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [7:0]        o_slave_id
);

    logic [7:0] r_slave_id;
    logic       wr_en;
    logic       hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == REG_SLAVE_ID);
    assign wr_en  = psel & penable & pwrite & pready & hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id <= 8'h00;
        end else if (wr_en) begin
            r_slave_id <= pwdata[7:0];
        end
    end

    assign prdata     = hit ? {{(APB_DW-8){1'b0}}, r_slave_id} : '0;
    assign o_slave_id = r_slave_id;

endmodule

### rtl/mbrc_in_stage.sv
// Input register stage for received bytes.
module mbrc_in_stage
    import mbrc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbrc_in_if.sink      i_in,
    input  logic         i_advance,
    output t_item_slot   o_slot
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    // Refill while the held byte moves on in the same cycle
    assign i_in.ready = !r_valid || i_advance;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.item  = r_item;

endmodule

### rtl/mbrc_frame_check.sv
// Per-frame CRC, length and header checks with counters and result register.
module mbrc_frame_check
    import mbrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item_slot  i_slot,
    input  logic [7:0]  i_slave_id,
    output logic        o_advance,
    mbrc_out_if.source  o_out
);

    // Frame state
    logic [15:0]      r_crc;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_d0, r_d1;
    logic [7:0]       r_first, r_second;
    logic             r_ovf;
    logic [TOT_W-1:0] r_succ, r_fail, r_exc, r_retry;

    // Result register
    logic             r_out_valid;
    t_status          r_status;
    logic [7:0]       r_fn;
    logic [LEN_W-1:0] r_len;

    logic [15:0]      n_crc;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       n_first, n_second;
    logic             n_ovf;
    t_status          n_status;
    logic [TOT_W-1:0] n_succ, n_fail, n_exc, n_retry;
    logic [LEN_W-1:0] n_len;

    logic [7:0] b;
    logic       last;
    logic       finish;

    assign b    = i_slot.item.data_byte;
    assign last = i_slot.item.last_byte;

    // A non-final byte never needs the result register
    assign o_advance = i_slot.valid && (!last || !r_out_valid || o_out.ready);
    assign finish    = o_advance && last;

    always_comb begin
        n_first  = (r_cnt == '0) ? b : r_first;
        n_second = (r_cnt == CNT_W'(1)) ? b : r_second;
        n_crc    = (r_cnt >= CRC_START) ? crc_feed(r_crc, r_d1) : r_crc;
        n_cnt    = (r_cnt <= MAX_CNT) ? r_cnt + CNT_W'(1) : r_cnt;
        n_ovf    = r_ovf || (n_cnt > MAX_CNT);

        // Received CRC: r_d0 is low byte, b is high byte
        if (n_cnt < MIN_CNT || n_ovf) begin
            n_status = ST_SHORT;
        end else if (n_first != i_slave_id) begin
            n_status = ST_BAD_ID;
        end else if (n_crc[7:0] != r_d0 || n_crc[15:8] != b) begin
            n_status = ST_CRC;
        end else if ((n_second & EXC_MASK) != 8'h00) begin
            n_status = ST_EXC;
        end else if (!fn_known(n_second)) begin
            n_status = ST_ILL_FN;
        end else begin
            n_status = ST_OK;
        end

        n_succ  = r_succ;
        n_fail  = r_fail;
        n_exc   = r_exc;
        n_retry = r_retry;
        n_len   = '0;
        if (n_status == ST_OK) begin
            n_succ  = r_succ + TOT_W'(1);
            n_retry = '0;
            n_len   = LEN_W'(n_cnt - HDR_CRC_LEN);
        end else begin
            if (n_status == ST_EXC) begin
                n_exc = r_exc + TOT_W'(1);
            end
            n_fail  = r_fail + TOT_W'(1);
            n_retry = r_retry + TOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_cnt    <= '0;
            r_d0     <= 8'h00;
            r_d1     <= 8'h00;
            r_first  <= 8'h00;
            r_second <= 8'h00;
            r_ovf    <= 1'b0;
            r_succ   <= '0;
            r_fail   <= '0;
            r_exc    <= '0;
            r_retry  <= '0;
        end else if (finish) begin
            // Report and start a fresh frame
            r_crc    <= CRC_INIT;
            r_cnt    <= '0;
            r_d0     <= 8'h00;
            r_d1     <= 8'h00;
            r_first  <= 8'h00;
            r_second <= 8'h00;
            r_ovf    <= 1'b0;
            r_succ   <= n_succ;
            r_fail   <= n_fail;
            r_exc    <= n_exc;
            r_retry  <= n_retry;
        end else if (o_advance) begin
            r_crc    <= n_crc;
            r_cnt    <= n_cnt;
            r_d0     <= b;
            r_d1     <= r_d0;
            r_first  <= n_first;
            r_second <= n_second;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status <= n_status;
            r_fn     <= n_second;
            r_len    <= n_len;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.function_code   = r_fn;
    assign o_out.payload_length  = r_len;
    assign o_out.success_count   = r_succ;
    assign o_out.failure_count   = r_fail;
    assign o_out.exception_count = r_exc;
    assign o_out.retry_count     = r_retry;

endmodule

### rtl/modbus_rtu_reply_checker_top.sv
// Path: an accepted final byte goes through the input register and then into the result register.
// Throughput: one byte per cycle; the input register and the result register
// let a new byte enter while a report waits, and only a final byte waits on it.
// Counters update with each report and are shown with it.
// Reset (synchronous, active low) clears frame state, counters and slave id.
// Top level: Modbus RTU reply checker.
module modbus_rtu_reply_checker_top
    import mbrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbrc_in_if.sink           i_in,
    mbrc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [7:0] slave_id;
    logic       advance;
    t_item_slot slot;

    mbrc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_slave_id (slave_id)
    );

    mbrc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_slot    (slot)
    );

    mbrc_frame_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot     (slot),
        .i_slave_id (slave_id),
        .o_advance  (advance),
        .o_out      (o_out)
    );

endmodule
